// ===== design/binary128_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// binary128_to_decimal_ascii assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BINARY128_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY128_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B2DA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da assertion failed");

// next-cycle implication
`define B2DA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da assertion failed");

`else

`define B2DA_ASSERT_IMP(lbl, ante, cons)
`define B2DA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants, item types and controller/datapath command and status.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int unsigned VALUE_BITS  = 128;
  localparam int unsigned DIGIT_SLOTS = 40;
  localparam int unsigned MAX_RESULTS = 40;

  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned SLOT_CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned RES_CNT_W  = $clog2(MAX_RESULTS);

  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;

  localparam logic [3:0] DIGIT_HALF = 4'd5;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [4:0] DIGIT_BASE = 5'd10;

  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic skip;
    logic emit_digit;
  } b2da_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic lead_zero;
    logic last;
    logic out_free;
  } b2da_status_t;

endpackage

// ===== design/b2da_datapath.sv =====
// ----------------------------------------------------------------------------
// b2da_datapath
// Magnitude shift register, decimal digit row, counters and output register.
// ----------------------------------------------------------------------------
`include "binary128_to_decimal_ascii_macros.svh"

module b2da_datapath import b2da_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_item_i,
  input  b2da_cmd_t    cmd_i,
  output b2da_status_t status_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output out_item_t    out_item_o
);

  logic [127:0]            raw;
  logic [VALUE_BITS-1:0]   val;
  logic                    sign;
  logic [VALUE_BITS-1:0]   mag;

  logic [VALUE_BITS-1:0]             mag_q;
  logic [DIGIT_SLOTS-1:0][3:0]       dig_q, dig_d, dig_step;
  logic [DIGIT_SLOTS-1:0]            carry_in;
  logic                              neg_q;
  logic [BIT_CNT_W-1:0]              bit_cnt_q, bit_cnt_d;
  logic [SLOT_CNT_W-1:0]             rem_q, rem_d;
  logic [RES_CNT_W-1:0]              res_cnt_q, res_cnt_d;
  logic                              out_valid_q, out_valid_d;
  out_item_t                         out_item_q, out_item_d;
  logic [3:0]                        top_digit;
  logic                              last;

  assign raw  = {in_item_i.value_high, in_item_i.value_low};
  assign val  = raw[VALUE_BITS-1:0];
  assign sign = val[VALUE_BITS-1];
  assign mag  = sign ? (~val + VALUE_BITS'(1)) : val;

  always_comb begin
    logic [4:0] dbl;
    carry_in[0] = mag_q[VALUE_BITS-1];
    for (int d = 1; d < DIGIT_SLOTS; d++) begin
      carry_in[d] = (dig_q[d-1] >= DIGIT_HALF);
    end
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      dbl = {dig_q[d], carry_in[d]};
      dig_step[d] = (dig_q[d] >= DIGIT_HALF) ? 4'(dbl - DIGIT_BASE) : dbl[3:0];
    end
  end

  assign top_digit = dig_q[DIGIT_SLOTS-1];
  assign last      = (rem_q == SLOT_CNT_W'(1)) || (res_cnt_q == RES_CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    res_cnt_d   = res_cnt_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      bit_cnt_d = BIT_CNT_W'(VALUE_BITS - 1);
      rem_d     = SLOT_CNT_W'(DIGIT_SLOTS);
      res_cnt_d = '0;
      dig_d     = '0;
    end
    if (cmd_i.step) begin
      bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
      dig_d     = dig_step;
    end
    if (cmd_i.skip || cmd_i.emit_digit) begin
      dig_d = {dig_q[DIGIT_SLOTS-2:0], 4'd0};
      rem_d = rem_q - SLOT_CNT_W'(1);
    end
    if (cmd_i.emit_sign) begin
      res_cnt_d             = res_cnt_q + RES_CNT_W'(1);
      out_valid_d           = 1'b1;
      out_item_d.ascii_char = ASCII_MINUS;
      out_item_d.last_char  = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      res_cnt_d             = res_cnt_q + RES_CNT_W'(1);
      out_valid_d           = 1'b1;
      out_item_d.ascii_char = ASCII_ZERO + {4'd0, top_digit};
      out_item_d.last_char  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        neg_q <= sign;
      end
      bit_cnt_q   <= bit_cnt_d;
      rem_q       <= rem_d;
      res_cnt_q   <= res_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag;
    end else if (cmd_i.step) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
    end
    dig_q      <= dig_d;
    out_item_q <= out_item_d;
  end

  assign status_o.conv_done = (bit_cnt_q == '0);
  assign status_o.neg       = neg_q;
  assign status_o.lead_zero = (top_digit == 4'd0) && (rem_q != SLOT_CNT_W'(1));
  assign status_o.last      = last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `B2DA_ASSERT_IMP(a_char_range, out_valid_q,
                   (out_item_q.ascii_char == ASCII_MINUS) ||
                   ((out_item_q.ascii_char >= ASCII_ZERO) &&
                    (out_item_q.ascii_char <= ASCII_NINE)))
  `B2DA_ASSERT_NXT(a_top_digit_decimal, cmd_i.step, dig_q[DIGIT_SLOTS-1] <= DIGIT_MAX)

endmodule

// ===== design/b2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: load, convert bit by bit, emit sign, drop leading zeros, emit.
// ----------------------------------------------------------------------------
`include "binary128_to_decimal_ascii_macros.svh"

module b2da_ctrl import b2da_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  b2da_status_t status_i,
  output b2da_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SIGN  = 5'b00100,
    S_SKIP  = 5'b01000,
    S_DIGIT = 5'b10000
  } b2da_state_e;

  b2da_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.conv_done) begin
          state_d = status_i.neg ? S_SIGN : S_SKIP;
        end
      end
      S_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status_i.lead_zero) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  `B2DA_ASSERT_IMP(a_emit_needs_room, cmd_o.emit_sign || cmd_o.emit_digit, status_i.out_free)
  `B2DA_ASSERT_NXT(a_last_ends_item, cmd_o.emit_digit && status_i.last, state_q == S_IDLE)
  `B2DA_ASSERT_NXT(a_sign_only_if_neg, cmd_o.step && status_i.conv_done && !status_i.neg, state_q == S_SKIP)

endmodule

// ===== design/binary128_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary128_to_decimal_ascii
// Signed 128-bit integer to decimal ASCII text, one character per item.
// ----------------------------------------------------------------------------
//  channel  direction  payload                          handshake
//  in       input      in_item_i  (value_high, low)     in_valid_i / in_ready_o
//  out      output     out_item_o (ascii_char, last)    out_valid_o / out_ready_i
//
//  Per value: a load, VALUE_BITS doubling steps of the digit row, a sign for
//  a negative value, then each digit slot in turn (a leading zero dropped or a
//  digit emitted), and a step to leave the zero skip.
//  Reset clears the sequencer and the output valid; no clearing pass.
//  A stalled output holds the sequencer in place; the next value is taken
//  once the last character sits in the output register.
// ----------------------------------------------------------------------------
module binary128_to_decimal_ascii import b2da_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  b2da_cmd_t    cmd;
  b2da_status_t status;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  b2da_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/b2da_text_checker.sv =====
// ----------------------------------------------------------------------------
// b2da_text_checker
// Watches both channels of binary128_to_decimal_ascii. Each accepted value is
// turned into its expected signed decimal text, one character per item, and
// every character the block emits is compared against the oldest one waiting.
// ----------------------------------------------------------------------------
module b2da_text_checker import b2da_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatch_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  out_item_t text_due[$];

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < PRINT_CAP) begin
      $display("[%0t] b2da mismatch: %s", $time, what);
    end
    mismatch_count_o++;
  endtask

  // Signed decimal text of one 128-bit two's-complement value.
  task automatic push_decimal_text(input in_item_t v);
    logic [127:0] value;
    logic [127:0] mag;
    logic [3:0]   digits [DIGIT_SLOTS];
    logic         neg;
    int           top;
    int           count;
    out_item_t    ch;
    value = {v.value_high, v.value_low};
    neg   = value[VALUE_BITS-1];
    mag   = neg ? (~value + 128'd1) : value;
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      digits[d] = 4'(mag % 128'd10);
      mag       = mag / 128'd10;
    end
    count = 0;
    if (neg) begin
      ch.ascii_char = ASCII_MINUS;
      ch.last_char  = 1'b0;
      text_due.push_back(ch);
      count++;
    end
    top = DIGIT_SLOTS - 1;
    while (top > 0 && digits[top] == 4'd0) top--;
    for (int d = top; d >= 0 && count < MAX_RESULTS; d--) begin
      ch.ascii_char = ASCII_ZERO + 8'(digits[d]);
      ch.last_char  = (d == 0) || (count == MAX_RESULTS - 1);
      text_due.push_back(ch);
      count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      text_due.delete();
      mismatch_count_o = 0;
      pending_o        <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        push_decimal_text(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    out_item_i.ascii_char, out_item_i.last_char));
        end else begin
          want = text_due.pop_front();
          if (out_item_i.ascii_char !== want.ascii_char) begin
            report_mismatch($sformatf("ascii_char got 0x%02h want 0x%02h",
                                      out_item_i.ascii_char, want.ascii_char));
          end
          if (out_item_i.last_char !== want.last_char) begin
            report_mismatch($sformatf("last_char got %0b want %0b on 0x%02h",
                                      out_item_i.last_char, want.last_char,
                                      want.ascii_char));
          end
        end
      end
      pending_o <= text_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the binary128_to_decimal_ascii bench. Drives directed edge values
// (zero, one, minus one, extremes, powers of ten) and then random values of
// mixed magnitude and sign, with random idling on both channels. Checking is
// done by b2da_text_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import b2da_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 350;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum int {SHAPE_FULL, SHAPE_SHIFTED, SHAPE_DECADE, SHAPE_SMALL} shape_e;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      steady    = 1'b0;
  int        mismatches;
  int        pending;
  int        stall_cycles = 0;

  binary128_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  b2da_text_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(negedge clk_i) begin
    out_ready = steady ? 1'b1 : ($urandom_range(99) >= 37);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [127:0] pow10(input int n);
    logic [127:0] p;
    p = 128'd1;
    for (int k = 0; k < n; k++) p = p * 128'd10;
    return p;
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] negate(input logic [127:0] x);
    return ~x + 128'd1;
  endfunction

  task automatic send_value(input logic [127:0] v);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item  = v;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_text_done();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [127:0] directed [$];
    logic [127:0] v;
    shape_e       shape;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed = '{
      128'd0, 128'd1, negate(128'd1), 128'd9, 128'd10, negate(128'd10),
      {1'b0, {127{1'b1}}}, {1'b1, 127'd0}, {1'b1, 126'd0, 1'b1},
      {64'd1, 64'd0}, {64'd0, {64{1'b1}}}, {{64{1'b1}}, 64'd0},
      pow10(38), pow10(38) - 128'd1, negate(pow10(38)), negate(pow10(38) - 128'd1),
      {64{2'b10}}, {64{2'b01}}, pow10(19), negate(pow10(19) + 128'd7),
      128'd99999, negate(128'd123456789), {128{1'b1}} >> 1
    };
    foreach (directed[k]) send_value(directed[k]);

    wait_text_done();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 120 && n < 200);
      if (n == 260) wait_text_done();
      shape = shape_e'($urandom_range(3));
      case (shape)
        SHAPE_FULL: begin
          v = rand128();
        end
        SHAPE_SHIFTED: begin
          v = rand128() >> $urandom_range(127);
          if ($urandom_range(1)) v = negate(v);
        end
        SHAPE_DECADE: begin
          v = pow10($urandom_range(38)) + 128'($urandom_range(2)) - 128'd1;
          if ($urandom_range(1)) v = negate(v);
        end
        default: begin
          v = 128'($urandom_range(999));
          if ($urandom_range(1)) v = negate(v);
        end
      endcase
      send_value(v);
    end
    steady = 1'b0;

    wait_text_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/b2da_pkg.sv
design/b2da_datapath.sv
design/b2da_ctrl.sv
design/binary128_to_decimal_ascii.sv
sim/b2da_text_checker.sv
sim/tb.sv
